FILE: rtl/sktab_pkg.sv
// ----------------------------------------------------------------------------
// sktab_pkg
// Shared types and constants of the sorted key table: item codes, result
// codes, controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sktab_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int KIND_W       = 2;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 9;

    // Item codes. The fourth code behaves as a lookup.
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_SHIFT,
        S_WRITE,
        S_CLEAR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic    load;      // capture the item and start the search window
        logic    srch_rd;   // read the middle entry of the window
        logic    srch_cmp;  // narrow the window with the entry just read
        logic    decide;    // latch the hit flag and set up the shift
        logic    shift;     // move one entry up a place
        logic    write;     // write the new pair and bump the count
        logic    clear;     // empty the table
        logic    out_load;  // load the result register
        t_status res;       // result code to load
    } t_dp_cmd;

    typedef struct packed {
        logic lo_lt_hi;     // search window not yet empty
        logic hit;          // key found at the insertion point
        logic full;         // table holds its capacity
        logic shift_more;   // entries still to move up
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/sktab_datapath.sv
// ----------------------------------------------------------------------------
// sktab_datapath
// Entry memory, binary search window, shift pointer, entry count and the
// result register of the sorted key table.
// ----------------------------------------------------------------------------
`default_nettype none

module sktab_datapath #(
    parameter int CAPACITY = sktab_pkg::DEF_CAPACITY
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sktab_pkg::t_dp_cmd            i_cmd,
    output sktab_pkg::t_dp_sts                 o_sts,
    input  wire logic [sktab_pkg::KEY_W-1:0]   i_key,
    input  wire logic [sktab_pkg::VAL_W-1:0]   i_entry_value,
    output logic      [1:0]                    o_status,
    output logic      [sktab_pkg::POS_W-1:0]   o_position,
    output logic      [sktab_pkg::VAL_W-1:0]   o_found_value
);
    import sktab_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int ENT_W = KEY_W + VAL_W;

    // Each entry holds the key in the upper half and the value in the lower.
    logic [ENT_W-1:0] r_mem [CAPACITY];
    logic [ENT_W-1:0] r_rd_data;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_lo;
    logic [CW-1:0]    r_hi;
    logic [CW-1:0]    r_mid;
    logic [CW-1:0]    r_idx;
    logic [AW-1:0]    r_waddr;
    logic             r_wpend;
    logic             r_hit;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [KEY_W-1:0] r_cand_key;
    logic [VAL_W-1:0] r_cand_val;
    t_status          r_out_status;
    logic [POS_W-1:0] r_out_pos;
    logic [VAL_W-1:0] r_out_value;

    logic [CW-1:0]    mid;
    logic [CW-1:0]    idx_dec;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [ENT_W-1:0] mem_wd;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic             hit;

    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign idx_dec = r_idx - CW'(1);
    assign rd_key  = r_rd_data[ENT_W-1:VAL_W];
    assign rd_val  = r_rd_data[VAL_W-1:0];
    assign hit     = (r_lo < r_count) && (r_cand_key == r_key);

    assign o_sts.lo_lt_hi   = r_lo < r_hi;
    assign o_sts.hit        = hit;
    assign o_sts.full       = r_count >= CW'(CAPACITY);
    assign o_sts.shift_more = r_idx > r_lo;

    always_comb begin
        rd_addr = i_cmd.srch_rd ? mid[AW-1:0] : idx_dec[AW-1:0];
        mem_we  = i_cmd.write || (i_cmd.shift && r_wpend);
        mem_wa  = i_cmd.write ? r_lo[AW-1:0] : r_waddr;
        mem_wd  = i_cmd.write ? {r_key, r_val} : r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_wpend <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_lo  <= '0;
                r_hi  <= r_count;
                r_hit <= 1'b0;
            end
            if (i_cmd.srch_cmp) begin
                if (rd_key < r_key) begin
                    r_lo <= r_mid + CW'(1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            if (i_cmd.decide) begin
                r_hit   <= hit;
                r_wpend <= 1'b0;
            end
            if (i_cmd.shift) begin
                r_wpend <= o_sts.shift_more;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.write) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
            r_val <= i_entry_value;
        end
        if (i_cmd.srch_rd) begin
            r_mid <= mid;
        end
        // The last entry at or above the key is the one at the final window.
        if (i_cmd.srch_cmp && !(rd_key < r_key)) begin
            r_cand_key <= rd_key;
            r_cand_val <= rd_val;
        end
        if (i_cmd.decide) begin
            r_idx <= r_count;
        end
        if (i_cmd.shift && o_sts.shift_more) begin
            r_idx   <= idx_dec;
            r_waddr <= r_idx[AW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.res;
            r_out_pos    <= POS_W'(r_lo);
            r_out_value  <= r_hit ? r_cand_val : '0;
        end
    end

    assign o_status      = r_out_status;
    assign o_position    = r_out_pos;
    assign o_found_value = r_out_value;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> (r_count < CW'(CAPACITY)) && !r_wpend)
        else $error("insert write into full table or with a shift pending");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lo <= r_hi) && (r_hi <= CW'(CAPACITY)))
        else $error("search window out of order");
`endif

endmodule

`default_nettype wire

FILE: rtl/sktab_ctrl.sv
// ----------------------------------------------------------------------------
// sktab_ctrl
// Controller of the sorted key table: sequences the search, the upward
// shift of entries on insert and the hand-over to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sktab_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [sktab_pkg::KIND_W-1:0]   i_kind,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output sktab_pkg::t_dp_cmd                  o_cmd,
    input  wire sktab_pkg::t_dp_sts             i_sts
);
    import sktab_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_status r_res;
    t_status n_res;
    logic    r_is_insert;
    logic    r_out_valid;
    logic    accept;
    logic    slot_free;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_kind == KIND_CLEAR) ? S_CLEAR : S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                n_state = i_sts.lo_lt_hi ? S_SRCH_CMP : S_DECIDE;
            end
            S_SRCH_CMP: begin
                n_state = S_SRCH_RD;
            end
            S_DECIDE: begin
                if (r_is_insert && !i_sts.hit && !i_sts.full) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SHIFT: begin
                if (!i_sts.shift_more) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_EMIT;
            end
            S_CLEAR: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res = r_res;
        case (r_state)
            S_DECIDE: begin
                if (r_is_insert) begin
                    if (i_sts.hit) begin
                        n_res = ST_DUP;
                    end else if (i_sts.full) begin
                        n_res = ST_FULL;
                    end else begin
                        n_res = ST_OK;
                    end
                end else begin
                    n_res = i_sts.hit ? ST_OK : ST_MISS;
                end
            end
            S_CLEAR: begin
                n_res = ST_OK;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.res = r_res;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_SRCH_RD: begin
                o_cmd.srch_rd = i_sts.lo_lt_hi;
            end
            S_SRCH_CMP: begin
                o_cmd.srch_cmp = 1'b1;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_EMIT: begin
                o_cmd.out_load = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_insert <= (i_kind == KIND_INSERT);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result loaded but not presented");

    a_no_shift_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && i_sts.hit) |=> (r_state == S_EMIT))
        else $error("table changed after a key was found");

    a_write_after_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |-> $past(r_state) == S_SHIFT)
        else $error("entry written without the shift before it");
`endif

endmodule

`default_nettype wire

FILE: rtl/sorted_key_table_search_insert.sv
// A lookup runs S binary search steps, where S is at most ceil(log2(count + 1)),
// nine at a capacity of 256. An insert that goes in then moves the entries above the
// position up one place each and writes the new pair.
// The table takes one item at a time; the next item can be taken in the cycle after
// the result is loaded.
// Reset clears the entry count, the search window, the flags and the controller; the memory is not swept.
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert
// Table of 32-bit keys with 32-bit values kept in ascending key order, with
// binary search lookup, ordered insert with duplicate and full checks, and
// clear.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_search_insert #(
    parameter int CAPACITY = sktab_pkg::DEF_CAPACITY
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [sktab_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [sktab_pkg::KEY_W-1:0]    i_key,
    input  wire logic [sktab_pkg::VAL_W-1:0]    i_entry_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [1:0]                     o_status,
    output logic      [sktab_pkg::POS_W-1:0]    o_position,
    output logic      [sktab_pkg::VAL_W-1:0]    o_found_value
);
    import sktab_pkg::*;

    // The controller issues one command bundle per cycle and reads back a
    // small status bundle; the entries, the search window and the result
    // register sit in the datapath.
    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller accepts an item only when idle. The result register
    // holds a finished result while the next item is taken and searched; a
    // second result waits, with the controller held, until the register is free.
    sktab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // The datapath keeps the entries in one memory with a registered read
    // port. Each search step reads the middle entry and then narrows the
    // window; the last entry found at or above the key is kept, so the hit
    // check needs no further read. An insert moves entries up one place per
    // cycle, reading the next one while writing the previous one.
    sktab_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_key         (i_key),
        .i_entry_value (i_entry_value),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_found_value (o_found_value)
    );

endmodule

`default_nettype wire

FILE: tb/sv/sorted_key_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_checker
// Watches both channels of the sorted key table. It keeps its own ordered copy
// of the keys and values and works out the result of every accepted item. It
// then compares each returned result, field by field, with the oldest one
// still awaited.
// ----------------------------------------------------------------------------
module sorted_key_table_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [sktab_pkg::KIND_W-1:0] i_kind,
    input  logic [sktab_pkg::KEY_W-1:0]  i_key,
    input  logic [sktab_pkg::VAL_W-1:0]  i_entry_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [1:0]                   i_status,
    input  logic [sktab_pkg::POS_W-1:0]  i_position,
    input  logic [sktab_pkg::VAL_W-1:0]  i_found_value,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked_count,
    output int                           o_hit_count,
    output int                           o_miss_count,
    output int                           o_dup_count,
    output int                           o_full_count,
    output int                           o_peak_entries
);
    import sktab_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   value;
    } t_lookup_result;

    logic [KEY_W-1:0] key_tab [CAPACITY];
    logic [VAL_W-1:0] val_tab [CAPACITY];
    int               entries = 0;
    t_lookup_result   awaited_results [$];

    int fails   = 0;
    int checked = 0;
    int hits    = 0;
    int misses  = 0;
    int dups    = 0;
    int fulls   = 0;
    int peak    = 0;

    // Applies one item to the shadow table and returns the result it should give.
    function automatic t_lookup_result search_and_update(
        input logic [KIND_W-1:0] kind,
        input logic [KEY_W-1:0]  key,
        input logic [VAL_W-1:0]  val
    );
        t_lookup_result res;
        int             lo;
        int             hi;
        int             mid;
        int             i;
        logic           hit;
        res.status   = ST_OK;
        res.position = '0;
        res.value    = '0;
        if (kind == KIND_CLEAR) begin
            entries = 0;
            return res;
        end
        lo = 0;
        hi = entries;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (key_tab[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        hit = 1'b0;
        if (lo < entries) begin
            hit = (key_tab[lo] == key);
        end
        res.position = POS_W'(lo);
        if (kind != KIND_INSERT) begin
            // Lookups, and the spare code which behaves as one.
            if (hit) begin
                res.value = val_tab[lo];
            end else begin
                res.status = ST_MISS;
            end
        end else if (hit) begin
            res.status = ST_DUP;
            res.value  = val_tab[lo];
        end else if (entries >= CAPACITY) begin
            res.status = ST_FULL;
        end else begin
            for (i = entries; i > lo; i--) begin
                key_tab[i] = key_tab[i - 1];
                val_tab[i] = val_tab[i - 1];
            end
            key_tab[lo] = key;
            val_tab[lo] = val;
            entries++;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            entries = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (awaited_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("Unexpected result: status %0d position %0d value %08h",
                                 i_status, i_position, i_found_value);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (i_status !== want.status || i_position !== want.position ||
                        i_found_value !== want.value) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("Mismatch on result %0d (expected/actual):", checked);
                            $display("  status %0d/%0d position %0d/%0d value %08h/%08h",
                                     want.status, i_status, want.position, i_position,
                                     want.value, i_found_value);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = search_and_update(i_kind, i_key, i_entry_value);
                awaited_results.push_back(want);
                if (i_kind != KIND_CLEAR) begin
                    case (want.status)
                        ST_OK:   hits += (i_kind != KIND_INSERT);
                        ST_MISS: misses++;
                        ST_DUP:  dups++;
                        ST_FULL: fulls++;
                        default: ;
                    endcase
                end
                if (entries > peak) begin
                    peak = entries;
                end
            end
        end
        o_fail_count    <= fails;
        o_pending       <= awaited_results.size();
        o_checked_count <= checked;
        o_hit_count     <= hits;
        o_miss_count    <= misses;
        o_dup_count     <= dups;
        o_full_count    <= fulls;
        o_peak_entries  <= peak;
    end

endmodule

FILE: tb/sv/sorted_key_table_search_insert_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert_test
// Drives lookup, insert, clear and spare-code items into the sorted key table
// and leaves the checking to a separate checker module that sits beside it.
// A short directed part covers the edge cases. The table is then filled to
// capacity, and random traffic follows under four idling patterns on the two
// handshakes.
// ----------------------------------------------------------------------------
module sorted_key_table_search_insert_test;

    import sktab_pkg::*;

    // The fourth item code has no name in the package; the block treats it as a lookup.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int ITEMS_PER_PHASE = 350;
    // An insert into a nearly full table shifts up to 255 entries after an
    // eight-step search; the settle time is sized to cover the longest item.
    localparam int SETTLE_CYCLES = 600;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [KIND_W-1:0] kind        = KIND_LOOKUP;
    logic [KEY_W-1:0]  key         = '0;
    logic [VAL_W-1:0]  entry_value = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [1:0]        status;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  found_value;

    int fail_count;
    int pending;
    int checked_count;
    int hit_count;
    int miss_count;
    int dup_count;
    int full_count;
    int peak_entries;

    // Idling percentages for the sender and the receiver, changed per phase.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int items_sent         = 0;

    // Keys that have been offered for insertion since the last clear. They
    // are used only to steer the stimulus towards hits and duplicates.
    logic [KEY_W-1:0] offered_keys [$];

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    sorted_key_table_search_insert uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_kind        (kind),
        .i_key         (key),
        .i_entry_value (entry_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_position    (position),
        .o_found_value (found_value)
    );

    sorted_key_table_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_kind          (kind),
        .i_key           (key),
        .i_entry_value   (entry_value),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_status        (status),
        .i_position      (position),
        .i_found_value   (found_value),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked_count (checked_count),
        .o_hit_count     (hit_count),
        .o_miss_count    (miss_count),
        .o_dup_count     (dup_count),
        .o_full_count    (full_count),
        .o_peak_entries  (peak_entries)
    );

    // The receiver stalls cycle by cycle at the rate the current phase sets.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Picks a key that was offered earlier, or a fresh one if there are none.
    function automatic logic [KEY_W-1:0] offered_key();
        if (offered_keys.size() == 0) begin
            return $urandom;
        end
        return offered_keys[$urandom_range(0, offered_keys.size() - 1)];
    endfunction

    // Presents one item and returns at the clock edge where it is accepted.
    // The sender decides cycle by cycle whether to idle before the item, and
    // valid is only lowered on those cycles, so an item that follows straight
    // on never sees valid drop and rise in one time step.
    task automatic send_item(input logic [KIND_W-1:0] kind_v, input logic [KEY_W-1:0] key_v,
                             input logic [VAL_W-1:0] val_v);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= kind_v;
        key         <= key_v;
        entry_value <= val_v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Holds the sender back until every awaited result has come out. The
    // first edge lets the checker count the item that was just accepted.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        int               order [256];
        int               phase;
        int               n;
        int               j;
        int               pick;
        int               swap;
        int               r;
        logic [KEY_W-1:0] key_v;
        logic [VAL_W-1:0] val_v;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The table is empty after reset, so the first lookup
        // and the spare code must both miss at position zero.
        send_item(KIND_LOOKUP, 32'h1234_5678, 32'h0);
        send_item(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_INSERT, 32'h8000_0000, 32'h0000_0001);
        // Inserting the smallest key moves every entry up by one place.
        send_item(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(KIND_INSERT, 32'h0000_0000, 32'h1111_1111);
        send_item(KIND_LOOKUP, 32'h0000_0000, 32'h0);
        send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_item(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        send_item(KIND_SPARE, 32'h8000_0000, 32'h0);
        send_item(KIND_INSERT, 32'h0000_0001, 32'h5555_5555);
        send_item(KIND_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(KIND_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(KIND_LOOKUP, 32'h0000_0001, 32'h0);
        send_item(KIND_LOOKUP, 32'hAAAA_AAAB, 32'h0);
        send_item(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_LOOKUP, 32'h0000_0000, 32'h0);
        send_item(KIND_INSERT, 32'h0000_0042, 32'h0000_0042);
        send_item(KIND_CLEAR, 32'h0, 32'h0);
        drain_results();

        // Fill the table to capacity in a shuffled order. Every key has its own
        // top byte, so none of them collide, and flipping the lowest bit of a
        // stored key yields a key that is certainly new.
        for (j = 0; j < 256; j++) begin
            order[j] = j;
        end
        for (j = 255; j > 0; j--) begin
            pick        = $urandom_range(0, j);
            swap        = order[j];
            order[j]    = order[pick];
            order[pick] = swap;
        end
        for (j = 0; j < 256; j++) begin
            key_v = {order[j][7:0], 24'($urandom)};
            send_item(KIND_INSERT, key_v, $urandom);
            offered_keys.push_back(key_v);
        end
        // The table is now full. New keys are refused at either end and in the
        // middle, whereas a key that is already there still reports a duplicate.
        send_item(KIND_INSERT, 32'h0000_0000, $urandom);
        send_item(KIND_INSERT, 32'hFFFF_FFFF, $urandom);
        send_item(KIND_INSERT, offered_keys[17] ^ 32'h1, $urandom);
        send_item(KIND_INSERT, offered_keys[5], $urandom);
        for (j = 0; j < 8; j++) begin
            send_item(KIND_LOOKUP, offered_key(), $urandom);
        end
        send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_item(KIND_CLEAR, $urandom, $urandom);
        offered_keys.delete();
        drain_results();

        // Random traffic. Most items are well-formed inserts, lookups of keys
        // that are present, and duplicate inserts. Misses, the spare code and
        // the occasional clear make up the rest and keep the table small.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct <= 0;
                end
                1: begin
                    sender_idle_pct    = 74;
                    receiver_stall_pct <= 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct <= 74;
                end
                default: begin
                    sender_idle_pct    = 8;
                    receiver_stall_pct <= 8;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                r     = $urandom_range(0, 99);
                val_v = $urandom;
                if (r < 35) begin
                    case ($urandom_range(0, 9))
                        0, 1:    key_v = $urandom_range(0, 31);
                        2:       key_v = offered_key() + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
                        3:       key_v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                        default: key_v = $urandom;
                    endcase
                    send_item(KIND_INSERT, key_v, val_v);
                    offered_keys.push_back(key_v);
                end else if (r < 50) begin
                    send_item(KIND_INSERT, offered_key(), val_v);
                end else if (r < 75) begin
                    send_item(KIND_LOOKUP, offered_key(), val_v);
                end else if (r < 90) begin
                    key_v = $urandom_range(0, 1) ? offered_key() + 32'd1 : 32'($urandom);
                    send_item(KIND_LOOKUP, key_v, val_v);
                end else if (r < 97) begin
                    send_item(KIND_SPARE, offered_key(), val_v);
                end else begin
                    send_item(KIND_CLEAR, $urandom, val_v);
                    offered_keys.delete();
                end
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items and checked %0d results: %0d hits, %0d misses,",
                 items_sent, checked_count, hit_count, miss_count);
        $display("%0d duplicates and %0d full refusals; the table held up to %0d entries.",
                 dup_count, full_count, peak_entries);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Guard against a hang. The watchdog delay leaves ample margin over
    // the slowest correct run.
    initial begin : watchdog
        #20_000_000;
        $display("Timed out with %0d results still awaited.", pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sorted_key_table_search_insert.f
rtl/sktab_pkg.sv
rtl/sktab_datapath.sv
rtl/sktab_ctrl.sv
rtl/sorted_key_table_search_insert.sv
tb/sv/sorted_key_table_checker.sv
tb/sv/sorted_key_table_search_insert_test.sv
